// ----- src/pdp_pkg.sv -----
// ----------------------------------------------------------------------------
// pdp_pkg
// Shared widths, window geometry, register codes and item structs for the
// pivot divergence position block.
// ----------------------------------------------------------------------------
package pdp_pkg;

    // window geometry
    localparam int LEFT_SPAN  = 2;
    localparam int RIGHT_SPAN = 2;
    localparam int WIN        = LEFT_SPAN + RIGHT_SPAN + 1;

    // field widths
    localparam int PRICE_W   = 32;
    localparam int OSC_W     = 15;
    localparam int POS_W     = 16;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXIT_THRESH = 2'd0,
        CFG_TRADE_QTY   = 2'd1
    } cfg_idx_t;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] EXIT_THRESH_RST = 15'd12800;
    localparam logic [CFG_W-1:0] TRADE_QTY_RST   = 15'd1;

    // one window slot
    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic               price_gap;
        logic [OSC_W-1:0]   osc;
        logic               osc_gap;
    } slot_t;

    // compare flags of one slot against the centre
    typedef struct packed {
        logic price_gt;
        logic price_lt;
        logic price_gap;
        logic osc_gt;
        logic osc_lt;
        logic osc_gap;
    } cmp_t;

    // pivot flags of the centre bar
    typedef struct packed {
        logic price_lo;
        logic price_hi;
        logic osc_lo;
        logic osc_hi;
    } piv_t;

    // one result item
    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    bull_div;
        logic                    bear_div;
    } res_t;

endpackage

// ----- src/pdp_if.sv -----
// ----------------------------------------------------------------------------
// pdp_bar_if / pdp_res_if
// Valid/ready channels for bar items in and result items out.
// ----------------------------------------------------------------------------
interface pdp_bar_if
    import pdp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PRICE_W-1:0] price;
    logic               price_missing;
    logic [OSC_W-1:0]   osc_value;
    logic               osc_missing;

    modport source (output valid, output price, output price_missing,
                    output osc_value, output osc_missing, input ready);
    modport sink   (input valid, input price, input price_missing,
                    input osc_value, input osc_missing, output ready);
endinterface

interface pdp_res_if
    import pdp_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] position;
    logic                    bull_div;
    logic                    bear_div;

    modport source (output valid, output position, output bull_div,
                    output bear_div, input ready);
    modport sink   (input valid, input position, input bull_div,
                    input bear_div, output ready);
endinterface

// ----- src/pdp_cell.sv -----
// ----------------------------------------------------------------------------
// pdp_cell
// One slot of the bar window: takes the neighbor's slot on a shift and
// compares its own contents against the centre bar.
// ----------------------------------------------------------------------------
module pdp_cell
    import pdp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift,
    input  slot_t              slot_in,
    input  logic [PRICE_W-1:0] centre_price,
    input  logic [OSC_W-1:0]   centre_osc,
    output slot_t              slot_out,
    output cmp_t               cmp
);

    slot_t slot_reg;
    slot_t slot_next;

    always_comb
    begin
        slot_next = shift ? slot_in : slot_reg;
    end

    // gap flags start set so a fresh window holds no pivot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg.price     <= '0;
            slot_reg.price_gap <= 1'b1;
            slot_reg.osc       <= '0;
            slot_reg.osc_gap   <= 1'b1;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot_out = slot_reg;

    // compare against the centre
    always_comb
    begin
        cmp.price_gt  = slot_reg.price > centre_price;
        cmp.price_lt  = slot_reg.price < centre_price;
        cmp.price_gap = slot_reg.price_gap;
        cmp.osc_gt    = slot_reg.osc > centre_osc;
        cmp.osc_lt    = slot_reg.osc < centre_osc;
        cmp.osc_gap   = slot_reg.osc_gap;
    end

endmodule

// ----- src/pdp_decide.sv -----
// ----------------------------------------------------------------------------
// pdp_decide
// Divergence test against the last joint pivots and the position update.
// ----------------------------------------------------------------------------
module pdp_decide
    import pdp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  piv_t               piv,
    input  logic [PRICE_W-1:0] centre_price,
    input  logic [OSC_W-1:0]   centre_osc,
    input  logic [OSC_W-1:0]   cur_osc,
    input  logic               cur_osc_missing,
    input  logic [CFG_W-1:0]   exit_thresh,
    input  logic [CFG_W-1:0]   trade_qty,
    output res_t               res
);

    logic                    have_lo_reg, have_lo_next;
    logic [PRICE_W-1:0]      lo_price_reg, lo_price_next;
    logic [OSC_W-1:0]        lo_osc_reg, lo_osc_next;
    logic                    have_hi_reg, have_hi_next;
    logic [PRICE_W-1:0]      hi_price_reg, hi_price_next;
    logic [OSC_W-1:0]        hi_osc_reg, hi_osc_next;
    logic signed [POS_W-1:0] pos_reg, pos_next;

    logic                    joint_lo, joint_hi;
    logic                    bull, bear;
    logic signed [POS_W-1:0] pos_exit;
    logic signed [POS_W-1:0] tgt;

    assign joint_lo = piv.price_lo && piv.osc_lo;
    assign joint_hi = piv.price_hi && piv.osc_hi;
    assign tgt      = $signed({1'b0, trade_qty});

    // divergence against the recorded pivot
    always_comb
    begin
        bull = joint_lo && have_lo_reg && (centre_price < lo_price_reg)
               && (centre_osc > lo_osc_reg);
        bear = joint_hi && have_hi_reg && (centre_price > hi_price_reg)
               && (centre_osc < hi_osc_reg);
    end

    // pivot memory, replaced by every joint pivot
    always_comb
    begin
        have_lo_next  = have_lo_reg;
        lo_price_next = lo_price_reg;
        lo_osc_next   = lo_osc_reg;
        have_hi_next  = have_hi_reg;
        hi_price_next = hi_price_reg;
        hi_osc_next   = hi_osc_reg;
        if (fire && joint_lo)
        begin
            have_lo_next  = 1'b1;
            lo_price_next = centre_price;
            lo_osc_next   = centre_osc;
        end
        if (fire && joint_hi)
        begin
            have_hi_next  = 1'b1;
            hi_price_next = centre_price;
            hi_osc_next   = centre_osc;
        end
    end

    // exit on the level cross, then open when flat; missing osc holds
    always_comb
    begin
        priority if (pos_reg > 0 && cur_osc >= exit_thresh)
            pos_exit = '0;
        else if (pos_reg < 0 && cur_osc <= exit_thresh)
            pos_exit = '0;
        else
            pos_exit = pos_reg;

        pos_next = pos_reg;
        if (fire && !cur_osc_missing)
        begin
            pos_next = pos_exit;
            if (pos_exit == 0)
            begin
                priority if (bull)
                    pos_next = tgt;
                else if (bear)
                    pos_next = -tgt;
                else
                    pos_next = pos_exit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_lo_reg  <= 1'b0;
            lo_price_reg <= '0;
            lo_osc_reg   <= '0;
            have_hi_reg  <= 1'b0;
            hi_price_reg <= '0;
            hi_osc_reg   <= '0;
            pos_reg      <= '0;
        end
        else
        begin
            have_lo_reg  <= have_lo_next;
            lo_price_reg <= lo_price_next;
            lo_osc_reg   <= lo_osc_next;
            have_hi_reg  <= have_hi_next;
            hi_price_reg <= hi_price_next;
            hi_osc_reg   <= hi_osc_next;
            pos_reg      <= pos_next;
        end
    end

    always_comb
    begin
        res.position = pos_next;
        res.bull_div = bull;
        res.bear_div = bear;
    end

endmodule

// ----- src/pivot_divergence_position_top.sv -----
// ----------------------------------------------------------------------------
// pivot_divergence_position_top
// Pivot divergence detector with a single managed position.
// ----------------------------------------------------------------------------
// Usage:
//   bar_in carries one bar item per handshake (price, oscillator, missing
//   flags); res_out returns one result item per bar: position held after the
//   bar and the bullish/bearish divergence flags confirmed at it.
//   cfg_we/cfg_index/cfg_data write the exit threshold (index 0) and the
//   trade quantity (index 1); other indexes are ignored. Write only while idle.
// Pipeline and throughput:
//   a bar shifts into the row of window cells at its accept edge; the pivot
//   compares and the position update run once the output register is free
//   and land in the output register, which then offers the result.
//   One item per cycle sustained while res_out.ready stays high.
// Reset:
//   every window slot is marked missing, so no pivot is seen until five bars
//   have arrived; pivot memory and position clear to flat, registers take
//   exit threshold 12800 and trade quantity 1.
// Stall:
//   the output register holds its item while res_out.ready is low; one more
//   bar is taken into the window, then bar_in.ready drops until it drains.
// ----------------------------------------------------------------------------
module pivot_divergence_position_top
    import pdp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    pdp_bar_if.sink              bar_in,
    pdp_res_if.source            res_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0] exit_thresh_reg;
    logic [CFG_W-1:0] trade_qty_reg;
    logic             pend_reg, pend_next;
    logic             out_vld_reg, out_vld_next;
    res_t             out_reg;
    logic             accept, fire;

    slot_t            new_slot;
    slot_t            slot_q [WIN];
    cmp_t             cmp    [WIN];
    piv_t             piv;
    res_t             res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exit_thresh_reg <= EXIT_THRESH_RST;
            trade_qty_reg   <= TRADE_QTY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EXIT_THRESH: exit_thresh_reg <= cfg_data;
                CFG_TRADE_QTY:   trade_qty_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // handshake: the window holds at most one unprocessed bar
    assign fire          = pend_reg && (!out_vld_reg || res_out.ready);
    assign bar_in.ready  = !pend_reg || fire;
    assign accept        = bar_in.valid && bar_in.ready;
    assign pend_next     = accept ? 1'b1 : (fire ? 1'b0 : pend_reg);
    assign out_vld_next  = fire ? 1'b1 : (res_out.ready ? 1'b0 : out_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            pend_reg    <= pend_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_comb
    begin
        new_slot.price     = bar_in.price;
        new_slot.price_gap = bar_in.price_missing;
        new_slot.osc       = bar_in.osc_value;
        new_slot.osc_gap   = bar_in.osc_missing;
    end

    // row of window cells, newest bar at the top slot
    for (genvar k = 0; k < WIN; k++)
    begin : g_cell
        pdp_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .shift        (accept),
            .slot_in      ((k == WIN - 1) ? new_slot : slot_q[(k + 1) % WIN]),
            .centre_price (slot_q[LEFT_SPAN].price),
            .centre_osc   (slot_q[LEFT_SPAN].osc),
            .slot_out     (slot_q[k]),
            .cmp          (cmp[k])
        );
    end

    // centre is a pivot when all slots are present and all others are beyond it
    always_comb
    begin
        piv.price_lo = 1'b1;
        piv.price_hi = 1'b1;
        piv.osc_lo   = 1'b1;
        piv.osc_hi   = 1'b1;
        for (int k = 0; k < WIN; k++)
        begin
            if (cmp[k].price_gap)
            begin
                piv.price_lo = 1'b0;
                piv.price_hi = 1'b0;
            end
            if (cmp[k].osc_gap)
            begin
                piv.osc_lo = 1'b0;
                piv.osc_hi = 1'b0;
            end
            if (k != LEFT_SPAN)
            begin
                if (!cmp[k].price_gt)
                    piv.price_lo = 1'b0;
                if (!cmp[k].price_lt)
                    piv.price_hi = 1'b0;
                if (!cmp[k].osc_gt)
                    piv.osc_lo = 1'b0;
                if (!cmp[k].osc_lt)
                    piv.osc_hi = 1'b0;
            end
        end
    end

    pdp_decide u_decide (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .piv             (piv),
        .centre_price    (slot_q[LEFT_SPAN].price),
        .centre_osc      (slot_q[LEFT_SPAN].osc),
        .cur_osc         (slot_q[WIN-1].osc),
        .cur_osc_missing (slot_q[WIN-1].osc_gap),
        .exit_thresh     (exit_thresh_reg),
        .trade_qty       (trade_qty_reg),
        .res             (res)
    );

    // output register
    always_ff @(posedge clk)
    begin
        if (fire)
            out_reg <= res;
    end

    assign res_out.valid    = out_vld_reg;
    assign res_out.position = out_reg.position;
    assign res_out.bull_div = out_reg.bull_div;
    assign res_out.bear_div = out_reg.bear_div;

endmodule

// ----- src/pdp_checker.sv -----
// ----------------------------------------------------------------------------
// pdp_checker
// Port-level checks of the pivot divergence block, bound to the top level.
// ----------------------------------------------------------------------------
module pdp_checker
    import pdp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic signed [POS_W-1:0] position,
    input  logic                    bull_div,
    input  logic                    bear_div
);

    // a stalled result item stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    // a stalled result item keeps its position
    a_pos_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(position))
        else $error("position changed while stalled");

    // a fresh result traces back to an accepted bar
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result item without a bar");

    // bullish and bearish divergence flags exclude each other
    a_one_signal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(bull_div && bear_div))
        else $error("both divergence flags set");

    // position magnitude never exceeds the 15-bit target
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> position != {1'b1, {(POS_W-1){1'b0}}})
        else $error("position out of range");

endmodule

bind pivot_divergence_position_top pdp_checker u_pdp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (bar_in.valid),
    .in_ready  (bar_in.ready),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .position  (res_out.position),
    .bull_div  (res_out.bull_div),
    .bear_div  (res_out.bear_div)
);
